// ===== design/jjvm_pkg.sv =====
// ----------------------------------------------------------------------------
// jjvm_pkg: shared types and constants for the joystick joint velocity mapper
// Item layouts, command kinds, register indices, widths and sign helpers.
// ----------------------------------------------------------------------------
package jjvm_pkg;

  localparam int unsigned AXIS_W      = 16;  // Q2.14 axes and Q4.12 joints
  localparam int unsigned CFG_W       = 15;  // configuration register width
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned FRAC_W      = 14;  // Q2.14 fraction bits
  localparam int unsigned STICK_W     = AXIS_W + 1;
  localparam int unsigned MAG_W       = 31;  // |P +- R| magnitude
  localparam int unsigned WIDE_W      = 32;  // signed P, R, a, b
  localparam int unsigned PROD_W      = MAG_W + CFG_W;
  localparam int unsigned QUO_W       = 15;  // wrist magnitude never exceeds dpad_velocity
  localparam int unsigned DIV_CW      = $clog2(QUO_W);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] DEADBAND_RST  = 15'd1311;
  localparam logic [CFG_W-1:0] MAX_VEL_RST   = 15'd6144;
  localparam logic [CFG_W-1:0] DPAD_VEL_RST  = 15'd1229;
  localparam logic [CFG_W-1:0] JOINT_MAX     = 15'd32767;

  typedef enum logic [1:0] {
    REG_DEADBAND = 2'd0,
    REG_MAX_VEL  = 2'd1,
    REG_DPAD_VEL = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_STATUS = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_ZERO = 2'd0,  // one zero command
    CMD_STOP = 2'd1,  // stop edge: two zero commands
    CMD_MOVE = 2'd2   // full velocity computation
  } cmd_kind_e;

  typedef struct packed {
    logic              op;
    logic              btn_enable;
    logic              btn_stop;
    logic signed [AXIS_W-1:0] left_x;
    logic signed [AXIS_W-1:0] left_y;
    logic signed [AXIS_W-1:0] right_x;
    logic signed [AXIS_W-1:0] right_y;
    logic signed [AXIS_W-1:0] pad_x;
    logic signed [AXIS_W-1:0] pad_y;
    logic              stop_status;
  } in_item_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] joint1;
    logic signed [AXIS_W-1:0] joint2;
    logic signed [AXIS_W-1:0] joint3;
    logic signed [AXIS_W-1:0] joint4;
    logic signed [AXIS_W-1:0] joint5;
    logic signed [AXIS_W-1:0] joint6;
    logic              last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
    logic [AXIS_W-1:0] pad_x;
    logic [AXIS_W-1:0] pad_y;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] deadband;
    logic [CFG_W-1:0] max_vel;
    logic [CFG_W-1:0] dpad_vel;
  } cfg_t;

  function automatic logic [AXIS_W-1:0] mag16(input logic [AXIS_W-1:0] v);
    mag16 = v[AXIS_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [AXIS_W-1:0] to_joint(input logic neg,
                                                 input logic [QUO_W-1:0] m);
    logic [AXIS_W-1:0] w;
    w = {1'b0, m};
    to_joint = neg ? (~w + 1'b1) : w;
  endfunction

endpackage

// ===== design/jjvm_in_if.sv =====
// ----------------------------------------------------------------------------
// jjvm_in_if: joystick sample / status update channel
// Valid/ready handshake carrying one input item.
// ----------------------------------------------------------------------------
interface jjvm_in_if;
  import jjvm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== design/jjvm_out_if.sv =====
// ----------------------------------------------------------------------------
// jjvm_out_if: joint velocity command channel
// Valid/ready handshake carrying one six-joint command.
// ----------------------------------------------------------------------------
interface jjvm_out_if;
  import jjvm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== design/jjvm_front.sv =====
// ----------------------------------------------------------------------------
// jjvm_front: input stage
// Holds the enable/stop latches and button history, classifies each sample.
// ----------------------------------------------------------------------------
module jjvm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  jjvm_in_if.sink        in_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output jjvm_pkg::cmd_t q_cmd_o
);
  import jjvm_pkg::*;

  logic enabled_q, enabled_d;
  logic stopped_q, stopped_d;
  logic prev_en_q, prev_stop_q;
  logic accept, is_sample, en_edge, stop_edge;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_sample  = (in_i.item.op == OP_SAMPLE);
  assign en_edge    = in_i.item.btn_enable && !prev_en_q && !stopped_q;
  assign stop_edge  = in_i.item.btn_stop && !prev_stop_q;
  assign q_push_o   = accept && is_sample;

  always_comb begin
    enabled_d = enabled_q;
    stopped_d = stopped_q;
    if (!is_sample) begin
      stopped_d = in_i.item.stop_status;
    end else begin
      if (en_edge) enabled_d = !enabled_q;
      if (stop_edge) begin
        stopped_d = 1'b1;
        enabled_d = 1'b0;
      end
    end
  end

  always_comb begin
    q_cmd_o.left_x  = in_i.item.left_x;
    q_cmd_o.left_y  = in_i.item.left_y;
    q_cmd_o.right_x = in_i.item.right_x;
    q_cmd_o.right_y = in_i.item.right_y;
    q_cmd_o.pad_x   = in_i.item.pad_x;
    q_cmd_o.pad_y   = in_i.item.pad_y;
    if (stop_edge) begin
      q_cmd_o.kind = CMD_STOP;
    end else if (!enabled_d || stopped_d) begin
      q_cmd_o.kind = CMD_ZERO;
    end else begin
      q_cmd_o.kind = CMD_MOVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      stopped_q   <= 1'b0;
      prev_en_q   <= 1'b0;
      prev_stop_q <= 1'b0;
    end else if (accept) begin
      enabled_q <= enabled_d;
      stopped_q <= stopped_d;
      if (is_sample) begin
        prev_en_q   <= in_i.item.btn_enable;
        prev_stop_q <= in_i.item.btn_stop;
      end
    end
  end

  // a stop edge always leaves the block stopped and disabled
  a_stop_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o && stop_edge |=> stopped_q && !enabled_q)
    else $error("stop edge did not latch stop");

endmodule

// ===== design/jjvm_queue.sv =====
// ----------------------------------------------------------------------------
// jjvm_queue: command queue
// Short FIFO between the classifier and the velocity engine.
// ----------------------------------------------------------------------------
module jjvm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jjvm_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output jjvm_pkg::cmd_t cmd_o
);
  import jjvm_pkg::*;

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0] count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

// ===== design/jjvm_back.sv =====
// ----------------------------------------------------------------------------
// jjvm_back: velocity engine
// Sequencer around one shared multiplier and a radix-2 divider for the wrist.
// ----------------------------------------------------------------------------
module jjvm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jjvm_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  jjvm_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  jjvm_out_if.source     out_o
);
  import jjvm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXTRA, ST_ZERO, ST_PREP, ST_MUL_L, ST_MUL_R, ST_MUL_PY,
    ST_MUL_PX, ST_SUM, ST_LIMIT, ST_MUL_W, ST_DIV, ST_EMIT
  } state_e;

  state_e              state_q;
  cmd_t                cmd_q;
  out_item_t           res_q, out_item_q;
  logic                out_valid_q;
  logic [AXIS_W-1:0]   l_mag_q, r_mag_q;
  logic                l_x_q, l_neg_q, r_x_q, r_neg_q;
  logic [PROD_W-1:0]   prod_q;
  logic [WIDE_W-1:0]   p_q, a_q, b_q;
  logic [MAG_W-1:0]    amag_q, bmag_q, div_q, rem_q;
  logic [QUO_W-1:0]    quo_q;
  logic [DIV_CW-1:0]   cnt_q;
  logic                big_q, wsel_q;

  logic                slot_free;
  logic [AXIS_W-1:0]   lx_m, ly_m, rx_m, ry_m;
  logic [MAG_W-1:0]    mul_x;
  logic [CFG_W-1:0]    mul_y;
  logic [PROD_W-1:0]   mul_p;
  logic [STICK_W-1:0]  stick_raw;
  logic [QUO_W-1:0]    stick_m;
  logic [WIDE_W-1:0]   prod_lo, prod_signed_y, prod_signed_x;
  logic [WIDE_W-1:0]   a_abs, b_abs;
  logic [MAG_W-1:0]    lmax, wlim, wm;
  logic                wneg;
  logic [WIDE_W-1:0]   dv_t, dv_sub;
  logic                dv_ge;
  logic [QUO_W-1:0]    quo_next;

  assign slot_free = !out_valid_q || out_o.ready;
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // deadbanded stick magnitudes
  always_comb begin
    lx_m = mag16(cmd_q.left_x);
    ly_m = mag16(cmd_q.left_y);
    rx_m = mag16(cmd_q.right_x);
    ry_m = mag16(cmd_q.right_y);
    if (lx_m <= {1'b0, cfg_i.deadband}) lx_m = '0;
    if (ly_m <= {1'b0, cfg_i.deadband}) ly_m = '0;
    if (rx_m <= {1'b0, cfg_i.deadband}) rx_m = '0;
    if (ry_m <= {1'b0, cfg_i.deadband}) ry_m = '0;
  end

  // shared multiplier operand select
  always_comb begin
    mul_x = '0;
    mul_y = cfg_i.dpad_vel;
    case (state_q)
      ST_MUL_L: begin
        mul_x = MAG_W'(l_mag_q);
        mul_y = cfg_i.max_vel;
      end
      ST_MUL_R: begin
        mul_x = MAG_W'(r_mag_q);
        mul_y = cfg_i.max_vel;
      end
      ST_MUL_PY: mul_x = MAG_W'(mag16(cmd_q.pad_y));
      ST_MUL_PX: mul_x = MAG_W'(mag16(cmd_q.pad_x));
      ST_MUL_W:  mul_x = wm;
      default:   mul_x = '0;
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // stick scaling: truncate Q2.14 product, saturate magnitude
  assign stick_raw = prod_q[FRAC_W+STICK_W-1:FRAC_W];
  assign stick_m   = (stick_raw > STICK_W'(JOINT_MAX)) ? JOINT_MAX : stick_raw[QUO_W-1:0];

  assign prod_lo       = prod_q[WIDE_W-1:0];
  assign prod_signed_y = cmd_q.pad_y[AXIS_W-1] ? (~prod_lo + 1'b1) : prod_lo;
  assign prod_signed_x = cmd_q.pad_x[AXIS_W-1] ? (~prod_lo + 1'b1) : prod_lo;

  assign a_abs = a_q[WIDE_W-1] ? (~a_q + 1'b1) : a_q;
  assign b_abs = b_q[WIDE_W-1] ? (~b_q + 1'b1) : b_q;
  assign lmax  = (a_abs[MAG_W-1:0] > b_abs[MAG_W-1:0]) ? a_abs[MAG_W-1:0]
                                                         : b_abs[MAG_W-1:0];
  assign wlim  = MAG_W'({cfg_i.dpad_vel, {FRAC_W{1'b0}}});

  assign wm   = wsel_q ? bmag_q : amag_q;
  assign wneg = wsel_q ? b_q[WIDE_W-1] : a_q[WIDE_W-1];

  // one restoring step: remainder always stays below the divisor
  assign dv_t     = {rem_q, quo_q[QUO_W-1]};
  assign dv_ge    = (dv_t >= {1'b0, div_q});
  assign dv_sub   = dv_t - {1'b0, div_q};
  assign quo_next = {quo_q[QUO_W-2:0], dv_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      res_q       <= '0;
      cmd_q       <= '0;
      l_mag_q     <= '0;
      r_mag_q     <= '0;
      l_x_q       <= 1'b0;
      l_neg_q     <= 1'b0;
      r_x_q       <= 1'b0;
      r_neg_q     <= 1'b0;
      prod_q      <= '0;
      p_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      amag_q      <= '0;
      bmag_q      <= '0;
      div_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      big_q       <= 1'b0;
      wsel_q      <= 1'b0;
    end else begin
      prod_q <= mul_p;
      if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cmd_q <= q_cmd_i;
            case (q_cmd_i.kind)
              CMD_STOP: state_q <= ST_EXTRA;
              CMD_ZERO: state_q <= ST_ZERO;
              default:  state_q <= ST_PREP;
            endcase
          end
        end
        ST_EXTRA: begin
          if (slot_free) begin
            out_item_q  <= '0;
            out_valid_q <= 1'b1;
            state_q     <= ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (slot_free) begin
            out_item_q      <= '0;
            out_item_q.last <= 1'b1;
            out_valid_q     <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end
        ST_PREP: begin
          // dominant axis per stick, x wins ties
          if (lx_m >= ly_m) begin
            l_mag_q <= lx_m;
            l_x_q   <= 1'b1;
            l_neg_q <= cmd_q.left_x[AXIS_W-1];
          end else begin
            l_mag_q <= ly_m;
            l_x_q   <= 1'b0;
            l_neg_q <= !cmd_q.left_y[AXIS_W-1];
          end
          if (rx_m >= ry_m) begin
            r_mag_q <= rx_m;
            r_x_q   <= 1'b1;
            r_neg_q <= !cmd_q.right_x[AXIS_W-1];
          end else begin
            r_mag_q <= ry_m;
            r_x_q   <= 1'b0;
            r_neg_q <= !cmd_q.right_y[AXIS_W-1];
          end
          res_q      <= '0;
          res_q.last <= 1'b1;
          state_q    <= ST_MUL_L;
        end
        ST_MUL_L: state_q <= ST_MUL_R;
        ST_MUL_R: begin
          if (l_x_q) res_q.joint1 <= to_joint(l_neg_q, stick_m);
          else       res_q.joint2 <= to_joint(l_neg_q, stick_m);
          state_q <= ST_MUL_PY;
        end
        ST_MUL_PY: begin
          if (r_x_q) res_q.joint3 <= to_joint(r_neg_q, stick_m);
          else       res_q.joint4 <= to_joint(r_neg_q, stick_m);
          state_q <= ST_MUL_PX;
        end
        ST_MUL_PX: begin
          p_q     <= prod_signed_y;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          a_q     <= p_q + prod_signed_x;
          b_q     <= p_q - prod_signed_x;
          state_q <= ST_LIMIT;
        end
        ST_LIMIT: begin
          amag_q  <= a_abs[MAG_W-1:0];
          bmag_q  <= b_abs[MAG_W-1:0];
          div_q   <= lmax;
          big_q   <= (lmax > wlim);
          wsel_q  <= 1'b0;
          state_q <= ST_MUL_W;
        end
        ST_MUL_W: begin
          if (big_q) begin
            rem_q   <= mul_p[PROD_W-1:QUO_W];
            quo_q   <= mul_p[QUO_W-1:0];
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            // within limit: plain Q6.26 -> Q4.12 truncation
            if (wsel_q) res_q.joint6 <= to_joint(wneg, wm[FRAC_W+QUO_W-1:FRAC_W]);
            else        res_q.joint5 <= to_joint(wneg, wm[FRAC_W+QUO_W-1:FRAC_W]);
            if (wsel_q) begin
              state_q <= ST_EMIT;
            end else begin
              wsel_q  <= 1'b1;
              state_q <= ST_MUL_W;
            end
          end
        end
        ST_DIV: begin
          rem_q <= dv_ge ? dv_sub[MAG_W-1:0] : dv_t[MAG_W-1:0];
          quo_q <= quo_next;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CW'(QUO_W - 1)) begin
            if (wsel_q) res_q.joint6 <= to_joint(wneg, quo_next);
            else        res_q.joint5 <= to_joint(wneg, quo_next);
            if (wsel_q) begin
              state_q <= ST_EMIT;
            end else begin
              wsel_q  <= 1'b1;
              state_q <= ST_MUL_W;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_item_q  <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // the only non-final command is the extra zero of a stop edge
  a_extra_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.item.last |->
      out_o.item.joint1 == '0 && out_o.item.joint2 == '0 && out_o.item.joint3 == '0 &&
      out_o.item.joint4 == '0 && out_o.item.joint5 == '0 && out_o.item.joint6 == '0)
    else $error("non-final command is not all zeros");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_q != '0)
    else $error("wrist divider running with zero divisor");

endmodule

// ===== design/joystick_joint_velocity_mapper_top.sv =====
// ----------------------------------------------------------------------------
// joystick_joint_velocity_mapper_top: joystick to joint velocity mapper
// Config registers, classifier front end, command queue and velocity engine.
// ----------------------------------------------------------------------------
//  port    | dir | handshake          | carries
//  in_i    | in  | valid/ready        | joystick sample or e-stop status update
//  out_o   | out | valid/ready        | six Q4.12 joint velocities + last flag
//  APB     | in  | psel/penable/pwrite| deadband, max velocity, d-pad velocity
//
// The front end takes one item per cycle while the two-entry queue has room;
// status updates are absorbed there and cause no command.
// Zero commands skip the multiplier sequence (a stop edge adds an extra zero
// command); a moving command runs the stick and wrist products, and each wrist
// joint beyond the limit goes through the bit-serial divider.
// Reset is asynchronous: latches clear, registers return to their defaults.
// A stalled output holds the engine; the queue keeps the front end accepting until it fills.
// ----------------------------------------------------------------------------
module joystick_joint_velocity_mapper_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  jjvm_in_if.sink                      in_i,
  jjvm_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jjvm_pkg::APB_AW-1:0]  paddr,
  input  logic [jjvm_pkg::APB_DW-1:0]  pwdata,
  output logic [jjvm_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import jjvm_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  logic     q_push, q_full, q_pop, q_valid;
  cmd_t     push_cmd, head_cmd;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband <= DEADBAND_RST;
      cfg_q.max_vel  <= MAX_VEL_RST;
      cfg_q.dpad_vel <= DPAD_VEL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEADBAND: cfg_q.deadband <= pwdata[CFG_W-1:0];
        REG_MAX_VEL:  cfg_q.max_vel  <= pwdata[CFG_W-1:0];
        REG_DPAD_VEL: cfg_q.dpad_vel <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEADBAND: prdata = APB_DW'(cfg_q.deadband);
      REG_MAX_VEL:  prdata = APB_DW'(cfg_q.max_vel);
      REG_DPAD_VEL: prdata = APB_DW'(cfg_q.dpad_vel);
      default:      prdata = '0;
    endcase
  end

  jjvm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  jjvm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  jjvm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the joystick joint velocity mapper
// Drives samples and e-stop updates with random gaps and output stalls,
// predicts every joint command from the latches and registers, and compares
// each command transfer field by field. Registers are rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import jjvm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 50;
  localparam int unsigned PHASE_ITEMS = 138;
  localparam int unsigned NUM_PHASES  = 6;

  class joint_cmd_scoreboard;
    longint      deadband;
    longint      max_vel;
    longint      dpad_vel;
    bit          enabled;
    bit          stopped;
    bit          prev_en_lvl;
    bit          prev_stop_lvl;
    out_item_t   pending_cmds[$];
    int unsigned n_errors;

    function new();
      deadband      = DEADBAND_RST;
      max_vel       = MAX_VEL_RST;
      dpad_vel      = DPAD_VEL_RST;
      enabled       = 1'b0;
      stopped       = 1'b0;
      prev_en_lvl   = 1'b0;
      prev_stop_lvl = 1'b0;
      n_errors      = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [APB_DW-1:0] data);
      case (idx)
        REG_DEADBAND: deadband = data[CFG_W-1:0];
        REG_MAX_VEL:  max_vel  = data[CFG_W-1:0];
        REG_DPAD_VEL: dpad_vel = data[CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint axis_mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint deadbanded(logic [AXIS_W-1:0] raw);
      longint v;
      v = longint'($signed(raw));
      return (axis_mag(v) > deadband) ? v : 0;
    endfunction

    function logic [AXIS_W-1:0] stick_joint(longint v, bit negate);
      longint m;
      m = (axis_mag(v) * max_vel) >>> FRAC_W;
      if (m > longint'(JOINT_MAX)) m = longint'(JOINT_MAX);
      if ((v < 0) != negate) m = -m;
      return m[AXIS_W-1:0];
    endfunction

    // wrist pair is rescaled together so the larger one lands on the limit
    function logic [AXIS_W-1:0] wrist_joint(longint v, longint largest);
      longint m;
      if (largest > (dpad_vel <<< FRAC_W)) m = (axis_mag(v) * dpad_vel) / largest;
      else m = axis_mag(v) >>> FRAC_W;
      if (v < 0) m = -m;
      return m[AXIS_W-1:0];
    endfunction

    function void note_input(in_item_t it);
      out_item_t cmd;
      longint    lx, ly, rx, ry, p, r, a, b, largest;
      if (it.op == OP_STATUS) begin
        stopped = it.stop_status;
        return;
      end
      if (it.btn_enable && !prev_en_lvl && !stopped) enabled = !enabled;
      cmd = '0;
      if (it.btn_stop && !prev_stop_lvl) begin
        stopped = 1'b1;
        enabled = 1'b0;
        pending_cmds.push_back(cmd);
      end
      prev_en_lvl   = it.btn_enable;
      prev_stop_lvl = it.btn_stop;
      cmd.last = 1'b1;
      if (enabled && !stopped) begin
        lx = deadbanded(it.left_x);
        ly = deadbanded(it.left_y);
        rx = deadbanded(it.right_x);
        ry = deadbanded(it.right_y);
        if (axis_mag(lx) >= axis_mag(ly)) cmd.joint1 = stick_joint(lx, 1'b0);
        else cmd.joint2 = stick_joint(ly, 1'b1);
        if (axis_mag(rx) >= axis_mag(ry)) cmd.joint3 = stick_joint(rx, 1'b1);
        else cmd.joint4 = stick_joint(ry, 1'b1);
        p = longint'($signed(it.pad_y)) * dpad_vel;
        r = longint'($signed(it.pad_x)) * dpad_vel;
        a = p + r;
        b = p - r;
        largest = (axis_mag(a) > axis_mag(b)) ? axis_mag(a) : axis_mag(b);
        cmd.joint5 = wrist_joint(a, largest);
        cmd.joint6 = wrist_joint(b, largest);
      end
      pending_cmds.push_back(cmd);
    endfunction

    function void check_field(string name, logic [AXIS_W-1:0] want,
                              logic [AXIS_W-1:0] got);
      if (want !== got) begin
        n_errors++;
        $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      end
    endfunction

    function void check_command(out_item_t got);
      out_item_t want;
      if (pending_cmds.size() == 0) begin
        n_errors++;
        $error("unexpected command transfer: joint1 %0d joint5 %0d last %0d",
               $signed(got.joint1), $signed(got.joint5), got.last);
        return;
      end
      want = pending_cmds.pop_front();
      check_field("joint1", want.joint1, got.joint1);
      check_field("joint2", want.joint2, got.joint2);
      check_field("joint3", want.joint3, got.joint3);
      check_field("joint4", want.joint4, got.joint4);
      check_field("joint5", want.joint5, got.joint5);
      check_field("joint6", want.joint6, got.joint6);
      check_field("last", AXIS_W'(want.last), AXIS_W'(got.last));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  bit                no_idle;
  int unsigned       cycle_cnt;
  joint_cmd_scoreboard sb;

  jjvm_in_if  in_if ();
  jjvm_out_if out_if ();

  joystick_joint_velocity_mapper_top u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** joystick_joint_velocity_mapper_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_command(out_if.item);
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(3, 1);
    if (sel < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall = no_idle ? 0 : gap_len();
      if (stall == 0) out_if.ready <= 1'b1;
      else begin
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  function automatic logic [AXIS_W-1:0] rand_axis(longint db);
    int unsigned sel;
    longint      v;
    sel = $urandom_range(99);
    if (sel < 10) v = longint'($urandom_range(16'hFFFF)) - 32768;
    else if (sel < 25) begin
      v = db + longint'($urandom_range(6)) - 3;
      if ($urandom_range(1)) v = -v;
    end else if (sel < 35) begin
      case ($urandom_range(6))
        0: v = -32768;
        1: v = -16384;
        2: v = -1;
        3: v = 0;
        4: v = 1;
        5: v = 16384;
        default: v = 32767;
      endcase
    end else v = longint'($urandom_range(32768)) - 16384;
    return v[AXIS_W-1:0];
  endfunction

  // biased so that most samples reach the moving state
  function automatic in_item_t rand_item();
    in_item_t it;
    it.left_x      = rand_axis(sb.deadband);
    it.left_y      = rand_axis(sb.deadband);
    it.right_x     = rand_axis(sb.deadband);
    it.right_y     = rand_axis(sb.deadband);
    it.pad_x       = rand_axis(sb.deadband);
    it.pad_y       = rand_axis(sb.deadband);
    it.stop_status = $urandom_range(1);
    it.op          = OP_SAMPLE;
    if ($urandom_range(99) < (sb.stopped ? 35 : 6)) begin
      it.op          = OP_STATUS;
      it.stop_status = $urandom_range(99) < (sb.stopped ? 20 : 40);
    end
    if (sb.prev_en_lvl) it.btn_enable = $urandom_range(1);
    else it.btn_enable = $urandom_range(99) < (sb.enabled ? 4 : 50);
    if (sb.prev_stop_lvl) it.btn_stop = $urandom_range(99) < 60;
    else it.btn_stop = $urandom_range(99) < 3;
    return it;
  endfunction

  function automatic in_item_t mk_sample(logic be, logic bs,
                                         logic [AXIS_W-1:0] lx, logic [AXIS_W-1:0] ly,
                                         logic [AXIS_W-1:0] rx, logic [AXIS_W-1:0] ry,
                                         logic [AXIS_W-1:0] px, logic [AXIS_W-1:0] py);
    in_item_t it;
    it.op          = OP_SAMPLE;
    it.btn_enable  = be;
    it.btn_stop    = bs;
    it.left_x      = lx;
    it.left_y      = ly;
    it.right_x     = rx;
    it.right_y     = ry;
    it.pad_x       = px;
    it.pad_y       = py;
    it.stop_status = $urandom_range(1);
    return it;
  endfunction

  // other fields are don't-care for a status update, so fill them with noise
  function automatic in_item_t mk_status(logic st);
    in_item_t it;
    it             = rand_item();
    it.op          = OP_STATUS;
    it.stop_status = st;
    it.btn_enable  = $urandom_range(1);
    it.btn_stop    = $urandom_range(1);
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : gap_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.item  <= it;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(it);
  endtask

  // wait for every command, then let any status update still in flight land
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] value, bit junk);
    logic [APB_DW-1:0] data;
    data = junk ? {$urandom} : '0;
    data[CFG_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic write_cfg(logic [CFG_W-1:0] db, logic [CFG_W-1:0] mv,
                           logic [CFG_W-1:0] dv, bit junk);
    write_reg(REG_DEADBAND, db, junk);
    write_reg(REG_MAX_VEL, mv, junk);
    write_reg(REG_DPAD_VEL, dv, junk);
  endtask

  task automatic run_directed();
    send_item(mk_sample(0, 0, 16384, 0, 0, 0, 0, 0));               // disabled
    send_item(mk_sample(1, 0, 16384, -16384, -16384, 16384, 16384, 16384)); // ties
    send_item(mk_sample(1, 0, -32768, 32767, 32767, -32768, -32768, 32767));
    send_item(mk_sample(0, 0, 1311, -1311, 1312, -1312, 0, 0));     // deadband edge
    send_item(mk_sample(0, 0, 100, -5000, 0, 9000, 100, 200));      // y wins, no limit
    send_item(mk_sample(0, 0, 0, 0, 0, 0, -16384, 16384));
    send_item(mk_sample(0, 0, 32767, 0, -1, 0, 32767, -32768));
    send_item(mk_sample(0, 1, 5000, 0, 0, 5000, 1000, 1000));       // stop edge
    send_item(mk_sample(1, 1, 5000, 0, 0, 5000, 1000, 1000));       // press while stopped
    settle();
    send_item(mk_status(1'b0));
    send_item(mk_sample(0, 0, 8000, 0, 0, 0, 0, 0));                // enable was cleared
    send_item(mk_sample(1, 0, -8000, 200, 300, -9000, 16384, 0));
    send_item(mk_status(1'b1));
    send_item(mk_sample(0, 0, 8000, 0, 0, 0, 0, 0));
    send_item(mk_status(1'b0));
    send_item(mk_sample(0, 0, 3000, -2000, -16384, 16384, -500, 700)); // resumes
    send_item(mk_sample(1, 0, 3000, 0, 0, 0, 0, 0));                // toggle off
    send_item(mk_sample(0, 0, 3000, 0, 0, 0, 0, 0));
    send_item(mk_sample(1, 0, 0, 16384, 16384, 0, 0, -16384));      // toggle on
    send_item(mk_sample(0, 1, 0, 16384, 16384, 0, 0, -16384));      // stop while moving
    send_item(mk_sample(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_sample(0, 1, 0, 0, 0, 0, 0, 0));                   // second stop edge
    send_item(mk_status(1'b0));
    send_item(mk_sample(1, 0, -32768, -32768, -32768, -32768, 0, 0));
  endtask

  initial begin
    sb        = new();
    no_idle   = 1'b0;
    cycle_cnt = 0;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.item  <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: write_cfg(15'd0, 15'd32767, 15'd32767, 1'b0);
        2: write_cfg(15'd16384, 15'd0, 15'd0, 1'b0);
        3: write_cfg(15'd32767, 15'd1, 15'd1, 1'b1);
        4: write_cfg($urandom_range(2500), $urandom_range(32767), $urandom_range(32767), 1'b1);
        5: write_cfg(15'd1311, $urandom_range(12288, 4096), $urandom_range(3000, 600), 1'b1);
        default: ;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        no_idle = (ph % 2 == 1) && (i < 25);   // back-to-back stretch
        send_item(rand_item());
      end
      no_idle = 1'b0;
      settle();
    end

    if (sb.n_errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("** joystick_joint_velocity_mapper_top: PASSED **");
    end else begin
      $display("** joystick_joint_velocity_mapper_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== joystick_joint_velocity_mapper_top.f =====
design/jjvm_pkg.sv
design/jjvm_in_if.sv
design/jjvm_out_if.sv
design/jjvm_front.sv
design/jjvm_queue.sv
design/jjvm_back.sv
design/joystick_joint_velocity_mapper_top.sv
verif/tb_top.sv
